[src/afip_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afip_pkg
// Shared constants, register indexes and beat payload types for the audio
// FIFO isochronous packetizer.
// ----------------------------------------------------------------------------
package afip_pkg;

  localparam int FIFO_PAIRS_DEF = 1024;
  localparam int MAX_FRAMES_DEF = 49;

  localparam int SAMPLE_W  = 16;
  localparam int PAIR_W    = 2 * SAMPLE_W;
  localparam int RATE_W    = 16;
  localparam int REG_IDX_W = 2;

  // Divide-by-1000 unit: the dividend is the rate, or remainder plus rate (17 bits).
  localparam int DIV_X_W    = 17;
  localparam int QUOT_W     = 7;
  localparam int REM_W      = 10;
  localparam int DIV_SHIFT  = 26;
  localparam int DIV_PROD_W = 2 * DIV_X_W;
  localparam logic [DIV_X_W-1:0] DIV_RECIP = 17'd67108;  // floor(2^26 / 1000)
  localparam logic [DIV_X_W-1:0] DIV_BASE  = 17'd1000;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd48000;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEVICE_MOUNTED = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STREAM_ACTIVE  = 2'd2;

  localparam logic ACTION_PUSH   = 1'b0;
  localparam logic ACTION_PACKET = 1'b1;
  localparam logic KIND_ACK      = 1'b0;
  localparam logic KIND_FRAME    = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } req_item_t;

  typedef struct packed {
    logic                       kind;
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] frame_left;
    logic signed [SAMPLE_W-1:0] frame_right;
    logic                       padded;
    logic                       last;
  } rsp_item_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [RATE_W-1:0]    wr_data;
  } cfg_item_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic [REM_W-1:0]  rem;
  } div_res_t;

endpackage : afip_pkg
`default_nettype wire

[src/afip_chan_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afip_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface afip_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface : afip_chan_if
`default_nettype wire

[src/audio_fifo_iso_packetizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// audio_fifo_iso_packetizer
// Stereo pair FIFO that builds isochronous packets of audio frames.
//
//   channel  role    beat
//   req      sink    action, left, right
//   rsp      source  kind, accepted, frame_left, frame_right, padded, last
//   cfg      sink    reg_index, wr_data
//
// A push is acknowledged directly when the response register is free, else
// through the ACK state. A packet runs one divide-by-1000 pass for a whole
// rate and two otherwise, then sends each frame padded from the held pair
// or popped through the registered memory read (FRAME, then FRAME_DATA).
// rst clears pointers, the fill count, the remainder and configuration; the
// pair memory is not cleared. A stalled rsp holds the sequencer while a new
// req beat may still be taken in the idle state.
module audio_fifo_iso_packetizer
  import afip_pkg::*;
#(
  parameter int FIFO_PAIRS = FIFO_PAIRS_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  afip_chan_if.sink   req,
  afip_chan_if.source rsp,
  afip_chan_if.sink   cfg
);

  localparam int PTR_W   = $clog2(FIFO_PAIRS);
  localparam int FILL_W  = $clog2(FIFO_PAIRS + 1);
  localparam int FRAME_W = $clog2(MAX_FRAMES + 1);

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_ACK        = 6'b000010,
    ST_DIV_RATE   = 6'b000100,
    ST_DIV_SUM    = 6'b001000,
    ST_FRAME      = 6'b010000,
    ST_FRAME_DATA = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [PTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [REM_W-1:0]    rate_rem, rate_rem_next;
  logic [RATE_W-1:0]   sample_rate;
  logic                device_mounted;
  logic                stream_active;
  logic [FRAME_W-1:0]  frames_left, frames_left_next;
  logic [SAMPLE_W-1:0] hold_l, hold_l_next;
  logic [SAMPLE_W-1:0] hold_r, hold_r_next;
  logic                ack_accepted, ack_accepted_next;
  logic                out_valid;
  rsp_item_t           out_item;

  logic                out_free;
  logic                out_load;
  rsp_item_t           out_load_item;
  logic                mem_we;
  logic                mem_re;
  logic [PAIR_W-1:0]   mem_rd_data;
  logic                div_start;
  logic [DIV_X_W-1:0]  div_x;
  logic                div_done;
  div_res_t            div_res;
  req_item_t           req_item;
  cfg_item_t           cfg_item;
  logic                req_fire;
  logic                fifo_full;
  logic                push_ok;
  logic                frames_ok;
  logic                last_frame;

  assign req_item  = req.payload;
  assign cfg_item  = cfg.payload;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign fifo_full = (fill == FILL_W'(FIFO_PAIRS));
  assign push_ok   = device_mounted && !fifo_full;
  assign frames_ok = (div_res.quot != '0) && (div_res.quot <= QUOT_W'(MAX_FRAMES));
  assign last_frame = (frames_left == FRAME_W'(1));

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  afip_pair_mem #(
    .DEPTH  (FIFO_PAIRS),
    .ADDR_W (PTR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_ptr),
    .wr_data ({req_item.right, req_item.left}),
    .rd_en   (mem_re),
    .rd_addr (rd_ptr),
    .rd_data (mem_rd_data)
  );

  afip_div1000 u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .x     (div_x),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    state_next        = state;
    wr_ptr_next       = wr_ptr;
    rd_ptr_next       = rd_ptr;
    fill_next         = fill;
    rate_rem_next     = rate_rem;
    frames_left_next  = frames_left;
    hold_l_next       = hold_l;
    hold_r_next       = hold_r;
    ack_accepted_next = ack_accepted;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    div_start         = 1'b0;
    div_x             = DIV_X_W'(sample_rate);
    out_load          = 1'b0;
    out_load_item     = '{kind: KIND_FRAME, accepted: 1'b1, frame_left: hold_l,
                          frame_right: hold_r, padded: 1'b1, last: last_frame};

    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_item.action == ACTION_PUSH) begin
            if (push_ok) begin
              mem_we      = 1'b1;
              wr_ptr_next = (wr_ptr == PTR_W'(FIFO_PAIRS - 1)) ? '0 : wr_ptr + PTR_W'(1);
              fill_next   = fill + FILL_W'(1);
            end
            if (out_free) begin
              out_load      = 1'b1;
              out_load_item = '{kind: KIND_ACK, accepted: !device_mounted || !fifo_full,
                                frame_left: '0, frame_right: '0, padded: 1'b0, last: 1'b1};
            end else begin
              ack_accepted_next = !device_mounted || !fifo_full;
              state_next        = ST_ACK;
            end
          end else if (stream_active) begin
            div_start  = 1'b1;
            state_next = ST_DIV_RATE;
          end
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_item = '{kind: KIND_ACK, accepted: ack_accepted,
                            frame_left: '0, frame_right: '0, padded: 1'b0, last: 1'b1};
          state_next    = ST_IDLE;
        end
      end
      ST_DIV_RATE: begin
        if (div_done) begin
          if (div_res.rem != '0) begin
            // Fractional rate: divide the carried remainder plus the rate.
            div_start  = 1'b1;
            div_x      = DIV_X_W'(rate_rem) + DIV_X_W'(sample_rate);
            state_next = ST_DIV_SUM;
          end else if (frames_ok) begin
            frames_left_next = FRAME_W'(div_res.quot);
            hold_l_next      = '0;
            hold_r_next      = '0;
            state_next       = ST_FRAME;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DIV_SUM: begin
        if (div_done) begin
          rate_rem_next = div_res.rem;
          if (frames_ok) begin
            frames_left_next = FRAME_W'(div_res.quot);
            hold_l_next      = '0;
            hold_r_next      = '0;
            state_next       = ST_FRAME;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FRAME: begin
        if (out_free) begin
          if (fill != '0) begin
            // The response register is empty when the read data arrives.
            mem_re      = 1'b1;
            rd_ptr_next = (rd_ptr == PTR_W'(FIFO_PAIRS - 1)) ? '0 : rd_ptr + PTR_W'(1);
            fill_next   = fill - FILL_W'(1);
            state_next  = ST_FRAME_DATA;
          end else begin
            out_load         = 1'b1;
            frames_left_next = frames_left - FRAME_W'(1);
            if (last_frame) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_FRAME_DATA: begin
        out_load         = 1'b1;
        out_load_item    = '{kind: KIND_FRAME, accepted: 1'b1,
                             frame_left: mem_rd_data[SAMPLE_W-1:0],
                             frame_right: mem_rd_data[PAIR_W-1:SAMPLE_W],
                             padded: 1'b0, last: last_frame};
        hold_l_next      = mem_rd_data[SAMPLE_W-1:0];
        hold_r_next      = mem_rd_data[PAIR_W-1:SAMPLE_W];
        frames_left_next = frames_left - FRAME_W'(1);
        state_next       = last_frame ? ST_IDLE : ST_FRAME;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // A rate write, or turning the stream off, restarts the remainder.
    if (cfg.valid && cfg.ready) begin
      if (cfg_item.reg_index == REG_SAMPLE_RATE ||
          (cfg_item.reg_index == REG_STREAM_ACTIVE && !cfg_item.wr_data[0])) begin
        rate_rem_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      fill           <= '0;
      rate_rem       <= '0;
      sample_rate    <= RATE_RESET;
      device_mounted <= 1'b0;
      stream_active  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state    <= state_next;
      wr_ptr   <= wr_ptr_next;
      rd_ptr   <= rd_ptr_next;
      fill     <= fill_next;
      rate_rem <= rate_rem_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_item.reg_index)
          REG_SAMPLE_RATE: begin
            sample_rate <= cfg_item.wr_data;
          end
          REG_DEVICE_MOUNTED: begin
            device_mounted <= cfg_item.wr_data[0];
          end
          REG_STREAM_ACTIVE: begin
            stream_active <= cfg_item.wr_data[0];
          end
          default: begin
          end
        endcase
      end
    end
    frames_left  <= frames_left_next;
    hold_l       <= hold_l_next;
    hold_r       <= hold_r_next;
    ack_accepted <= ack_accepted_next;
    if (out_load) begin
      out_item <= out_load_item;
    end
  end

endmodule : audio_fifo_iso_packetizer
`default_nettype wire

[src/afip_div1000.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afip_div1000
// Divide by 1000: registered reciprocal multiply, then one registered correction step.
// ----------------------------------------------------------------------------
module afip_div1000
  import afip_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_X_W-1:0] x,
  output logic                    done,
  output div_res_t                res
);

  logic                    prod_valid;
  logic [DIV_PROD_W-1:0]   prod;
  logic [DIV_X_W-1:0]      x_held;
  logic [QUOT_W-1:0]       q_est;
  logic [DIV_X_W-1:0]      r_est;
  div_res_t                res_next;

  // The estimate is the true quotient or one below it, so the remainder
  // stays under 2000 and one compare-and-subtract finishes the job.
  always_comb begin
    q_est = prod[DIV_SHIFT +: QUOT_W];
    r_est = x_held - DIV_X_W'(DIV_X_W'(q_est) * DIV_BASE);
    if (r_est >= DIV_BASE) begin
      res_next.quot = q_est + QUOT_W'(1);
      res_next.rem  = REM_W'(r_est - DIV_BASE);
    end else begin
      res_next.quot = q_est;
      res_next.rem  = REM_W'(r_est);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= start;
      done       <= prod_valid;
    end
    if (start) begin
      prod   <= DIV_PROD_W'(x) * DIV_PROD_W'(DIV_RECIP);
      x_held <= x;
    end
    if (prod_valid) begin
      res <= res_next;
    end
  end

endmodule : afip_div1000
`default_nettype wire

[src/afip_pair_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// afip_pair_mem
// Stereo pair store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module afip_pair_mem
  import afip_pkg::*;
#(
  parameter int DEPTH  = FIFO_PAIRS_DEF,
  parameter int ADDR_W = $clog2(FIFO_PAIRS_DEF)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [PAIR_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [PAIR_W-1:0] rd_data
);

  logic [PAIR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : afip_pair_mem
`default_nettype wire
